// File: rtl/nbpa_pkg.sv
package nbpa_pkg;

  localparam int ADDR_W     = 6;
  localparam int CFG_IDX_W  = 8;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 47;

  localparam logic [CFG_IDX_W-1:0] REG_GRAV_MASS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOFTENING = 8'd1;

  localparam logic signed [47:0] SAT_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SAT_MIN = 48'sh8000_0000_0000;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_WRITE,
    OP_READ,
    OP_CLR,
    OP_CAP_I,
    OP_DIFF,
    OP_SQ,
    OP_RSUM,
    OP_ZFLAG,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DEN0,
    OP_DEN1,
    OP_DEN2,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_ACC
  } dp_op_t;

  typedef struct packed {
    dp_op_t              op;
    logic [ADDR_W-1:0]   addr;
  } dp_cmd_t;

  typedef struct packed {
    logic r_zero;
  } dp_stat_t;

endpackage

// File: rtl/nbpa_ifs.sv
interface nbpa_in_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic              last_particle;
  modport source (output valid, pos_x, pos_y, pos_z, last_particle, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, last_particle, output ready);
endinterface

interface nbpa_out_if;
  logic              valid;
  logic              ready;
  logic signed [47:0] acc_x;
  logic signed [47:0] acc_y;
  logic signed [47:0] acc_z;
  logic [5:0]        particle_index;
  logic              overflow;
  logic              last_result;
  modport source (output valid, acc_x, acc_y, acc_z, particle_index, overflow, last_result,
                  input ready);
  modport sink   (input valid, acc_x, acc_y, acc_z, particle_index, overflow, last_result,
                  output ready);
endinterface

interface nbpa_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/nbpa_datapath.sv
module nbpa_datapath #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  nbpa_pkg::dp_cmd_t   cmd,
  output nbpa_pkg::dp_stat_t  stat,
  input  logic signed [31:0]  in_x,
  input  logic signed [31:0]  in_y,
  input  logic signed [31:0]  in_z,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_idx,
  input  logic [31:0]         cfg_data,
  output logic signed [47:0]  acc_x,
  output logic signed [47:0]  acc_y,
  output logic signed [47:0]  acc_z,
  output logic                ovf
);
  import nbpa_pkg::*;

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

  logic [95:0] mem [MAX_PARTICLES];
  logic [95:0] rd_q_r;

  logic [31:0] gm_r, sf_r;
  logic [47:0] e2_r;

  logic signed [31:0] pi_r  [3];
  logic signed [31:0] rd_pos [3];
  logic [32:0] mag_r [3];
  logic        neg_r [3];
  logic [47:0] sq_r  [3];
  logic [64:0] nm_r  [3];
  logic [49:0] r_r;
  logic [63:0] sx_r, sres_r, sbit_r;
  logic [56:0] p0_r, p1_r;
  logic [81:0] den_r;
  logic [82:0] rem_r [3];
  logic [46:0] nlo_r [3];
  logic [46:0] q_r   [3];
  logic        clamp_r [3];
  logic signed [47:0] sum_r [3];
  logic        flag_r;

  logic signed [32:0] d     [3];
  logic [32:0]        magc  [3];
  logic [65:0]        sqf   [3];
  logic [87:0]        num   [3];
  logic [82:0]        sh    [3];
  logic signed [47:0] term  [3];
  logic signed [48:0] tot   [3];
  logic [63:0]        strial;

  assign rd_pos[0] = rd_q_r[95:64];
  assign rd_pos[1] = rd_q_r[63:32];
  assign rd_pos[2] = rd_q_r[31:0];

  assign strial = sres_r + sbit_r;
  assign stat.r_zero = (r_r == '0);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d[k]    = {rd_pos[k][31], rd_pos[k]} - {pi_r[k][31], pi_r[k]};
      magc[k] = d[k][32] ? (~d[k] + 33'd1) : d[k];
      sqf[k]  = mag_r[k] * mag_r[k];
      num[k]  = {nm_r[k], 23'd0};
      sh[k]   = {rem_r[k][81:0], nlo_r[k][46]};
      term[k] = clamp_r[k] ? SAT_MAX : {1'b0, q_r[k]};
      if (neg_r[k]) begin
        term[k] = -term[k];
      end
      tot[k]  = {sum_r[k][47], sum_r[k]} + {term[k][47], term[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE) begin
      mem[cmd.addr[AW-1:0]] <= {in_x, in_y, in_z};
    end
    if (cmd.op == OP_READ) begin
      rd_q_r <= mem[cmd.addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gm_r <= 32'd65536;
      sf_r <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_GRAV_MASS: gm_r <= cfg_data;
        REG_SOFTENING: sf_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CLR: begin
        e2_r   <= 48'((64'(sf_r) * 64'(sf_r)) >> 16);
        flag_r <= 1'b0;
        for (int k = 0; k < 3; k++) sum_r[k] <= '0;
      end
      OP_CAP_I: begin
        for (int k = 0; k < 3; k++) pi_r[k] <= rd_pos[k];
      end
      OP_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          mag_r[k] <= magc[k];
          neg_r[k] <= d[k][32];
        end
      end
      OP_SQ: begin
        // square wraps at 64 bits, as the integer form does
        for (int k = 0; k < 3; k++) begin
          sq_r[k] <= sqf[k][63:16];
          nm_r[k] <= 65'(gm_r) * 65'(mag_r[k]);
        end
      end
      OP_RSUM: r_r <= 50'(sq_r[0]) + 50'(sq_r[1]) + 50'(sq_r[2]) + 50'(e2_r);
      OP_ZFLAG: flag_r <= 1'b1;
      OP_SQRT_INIT: begin
        sx_r   <= {r_r, 14'd0};
        sres_r <= '0;
        sbit_r <= 64'd1 << 62;
      end
      OP_SQRT_STEP: begin
        if (sx_r >= strial) begin
          sx_r   <= sx_r - strial;
          sres_r <= (sres_r >> 1) + sbit_r;
        end else begin
          sres_r <= sres_r >> 1;
        end
        sbit_r <= sbit_r >> 2;
      end
      OP_DEN0: p0_r  <= 57'(r_r[24:0]) * 57'(sres_r[31:0]);
      OP_DEN1: p1_r  <= 57'(r_r[49:25]) * 57'(sres_r[31:0]);
      OP_DEN2: den_r <= 82'(p0_r) + (82'(p1_r) << 25);
      OP_DIV_INIT: begin
        // a quotient of 2^47 or more clamps; keep only the low 47 bits
        for (int k = 0; k < 3; k++) begin
          clamp_r[k] <= 82'(num[k][87:47]) >= den_r;
          rem_r[k]   <= 83'(num[k][87:47]);
          nlo_r[k]   <= num[k][46:0];
          q_r[k]     <= '0;
        end
      end
      OP_DIV_STEP: begin
        for (int k = 0; k < 3; k++) begin
          nlo_r[k] <= {nlo_r[k][45:0], 1'b0};
          if (sh[k] >= {1'b0, den_r}) begin
            rem_r[k] <= sh[k] - {1'b0, den_r};
            q_r[k]   <= {q_r[k][45:0], 1'b1};
          end else begin
            rem_r[k] <= sh[k];
            q_r[k]   <= {q_r[k][45:0], 1'b0};
          end
        end
      end
      OP_ACC: begin
        for (int k = 0; k < 3; k++) begin
          if (tot[k] > 49'sd140737488355327) begin
            sum_r[k] <= SAT_MAX;
          end else if (tot[k] < -49'sd140737488355328) begin
            sum_r[k] <= SAT_MIN;
          end else begin
            sum_r[k] <= tot[k][47:0];
          end
        end
        if (clamp_r[0] || clamp_r[1] || clamp_r[2] ||
            (tot[0] > 49'sd140737488355327) || (tot[0] < -49'sd140737488355328) ||
            (tot[1] > 49'sd140737488355327) || (tot[1] < -49'sd140737488355328) ||
            (tot[2] > 49'sd140737488355327) || (tot[2] < -49'sd140737488355328)) begin
          flag_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign acc_x = sum_r[0];
  assign acc_y = sum_r[1];
  assign acc_z = sum_r[2];
  assign ovf   = flag_r;

endmodule

// File: rtl/nbpa_ctrl.sv
module nbpa_ctrl #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [5:0]         out_idx,
  output logic               out_last,
  output nbpa_pkg::dp_cmd_t  cmd,
  input  nbpa_pkg::dp_stat_t stat
);
  import nbpa_pkg::*;

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = $clog2(MAX_PARTICLES + 1);

  typedef enum logic [4:0] {
    S_LOAD, S_CLR, S_RDI, S_CAP_I, S_NEXT_J, S_DIFF, S_SQ, S_RSUM, S_RCHK,
    S_SQRT, S_DEN0, S_DEN1, S_DEN2, S_DIV_INIT, S_DIV, S_ACC, S_OUT
  } state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt, n_r, n_nxt, j_r, j_nxt;
  logic [AW-1:0]  i_r, i_nxt;
  logic [5:0]     step_r, step_nxt;
  logic [CW-1:0]  cnt_inc;
  logic           last_i;

  assign cnt_inc = (cnt_r < CW'(MAX_PARTICLES)) ? cnt_r + CW'(1) : cnt_r;
  assign last_i  = (CW'(i_r) + CW'(1)) == n_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    j_nxt     = j_r;
    i_nxt     = i_r;
    step_nxt  = step_r;
    cmd.op    = OP_NOP;
    cmd.addr  = '0;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          // drop the beat once the store is full
          if (cnt_r < CW'(MAX_PARTICLES)) begin
            cmd.op   = OP_WRITE;
            cmd.addr = ADDR_W'(cnt_r);
          end
          cnt_nxt = cnt_inc;
          if (in_last) begin
            n_nxt     = cnt_inc;
            i_nxt     = '0;
            state_nxt = S_CLR;
          end
        end
      end
      S_CLR: begin
        cmd.op    = OP_CLR;
        state_nxt = S_RDI;
      end
      S_RDI: begin
        cmd.op    = OP_READ;
        cmd.addr  = ADDR_W'(i_r);
        state_nxt = S_CAP_I;
      end
      S_CAP_I: begin
        cmd.op    = OP_CAP_I;
        j_nxt     = '0;
        state_nxt = S_NEXT_J;
      end
      S_NEXT_J: begin
        if (j_r == n_r) begin
          state_nxt = S_OUT;
        end else if (j_r == CW'(i_r)) begin
          j_nxt = j_r + CW'(1);
        end else begin
          cmd.op    = OP_READ;
          cmd.addr  = ADDR_W'(j_r);
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.op    = OP_DIFF;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.op    = OP_SQ;
        state_nxt = S_RSUM;
      end
      S_RSUM: begin
        cmd.op    = OP_RSUM;
        state_nxt = S_RCHK;
      end
      S_RCHK: begin
        if (stat.r_zero) begin
          cmd.op    = OP_ZFLAG;
          j_nxt     = j_r + CW'(1);
          state_nxt = S_NEXT_J;
        end else begin
          cmd.op    = OP_SQRT_INIT;
          step_nxt  = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.op   = OP_SQRT_STEP;
        step_nxt = step_r + 6'd1;
        if (step_r == 6'(SQRT_STEPS - 1)) begin
          state_nxt = S_DEN0;
        end
      end
      S_DEN0: begin
        cmd.op    = OP_DEN0;
        state_nxt = S_DEN1;
      end
      S_DEN1: begin
        cmd.op    = OP_DEN1;
        state_nxt = S_DEN2;
      end
      S_DEN2: begin
        cmd.op    = OP_DEN2;
        state_nxt = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.op    = OP_DIV_INIT;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op   = OP_DIV_STEP;
        step_nxt = step_r + 6'd1;
        if (step_r == 6'(DIV_STEPS - 1)) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.op    = OP_ACC;
        j_nxt     = j_r + CW'(1);
        state_nxt = S_NEXT_J;
      end
      S_OUT: begin
        if (out_ready) begin
          if (last_i) begin
            cnt_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            i_nxt     = i_r + AW'(1);
            state_nxt = S_CLR;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      n_r     <= '0;
      j_r     <= '0;
      i_r     <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
      j_r     <= j_nxt;
      i_r     <= i_nxt;
      step_r  <= step_nxt;
    end
  end

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = (state_r == S_OUT);
  assign out_idx   = 6'(i_r);
  assign out_last  = last_i;

endmodule

// File: rtl/nbody_pairwise_acceleration_unit.sv
// channel | dir | payload                                         | handshake
// in_ch   | in  | pos_x, pos_y, pos_z, last_particle              | valid/ready
// out_ch  | out | acc_x/y/z, particle_index, overflow, last_result | valid/ready
// cfg_ch  | in  | index, data                                     | valid/ready
// Loading accepts one beat per cycle. After the last beat each pair runs a 32-step
// square root and three 47-step dividers in lockstep; a pair whose r is zero
// (coincident, no softening) skips both and only sets the overflow flag.
// Reset (synchronous, rst_n low) empties the store and restores the registers.
// Input is held off while a set is being worked on; a stalled result holds the unit.
module nbody_pairwise_acceleration_unit #(
  parameter int MAX_PARTICLES = 64
) (
  input logic        clk,
  input logic        rst_n,
  nbpa_in_if.sink    in_ch,
  nbpa_out_if.source out_ch,
  nbpa_cfg_if.sink   cfg_ch
);
  import nbpa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  nbpa_ctrl #(.MAX_PARTICLES(MAX_PARTICLES)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last_particle),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_idx   (out_ch.particle_index),
    .out_last  (out_ch.last_result),
    .cmd       (cmd),
    .stat      (stat)
  );

  nbpa_datapath #(.MAX_PARTICLES(MAX_PARTICLES)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_x     (in_ch.pos_x),
    .in_y     (in_ch.pos_y),
    .in_z     (in_ch.pos_z),
    .cfg_we   (cfg_ch.valid),
    .cfg_idx  (cfg_ch.index),
    .cfg_data (cfg_ch.data),
    .acc_x    (out_ch.acc_x),
    .acc_y    (out_ch.acc_y),
    .acc_z    (out_ch.acc_z),
    .ovf      (out_ch.overflow)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input open while a result is offered");

  a_reload: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.last_result |=> in_ch.ready)
    else $error("no return to loading after the final result");

  a_first_idx: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.last_particle |=> !out_ch.valid)
    else $error("result offered straight after the last beat");

endmodule

// File: verif/nbpa_accel_checker.sv
module nbpa_accel_checker (
  input  logic clk,
  input  logic rst_n,
  nbpa_in_if   in_mon,
  nbpa_out_if  out_mon,
  nbpa_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending,
  output int   results_seen,
  output int   sets_seen,
  output int   overflow_seen
);
  import nbpa_pkg::*;

  localparam int DEPTH = 64;
  localparam longint ACC_MAX = 64'sd140737488355327;
  localparam longint ACC_MIN = -64'sd140737488355328;

  typedef struct {
    logic signed [47:0] ax;
    logic signed [47:0] ay;
    logic signed [47:0] az;
    logic [5:0]         idx;
    logic               ovf;
    logic               last;
  } accel_t;

  accel_t            accel_q[$];
  logic [31:0]       gm;
  logic [31:0]       eps;
  logic signed [63:0] px[DEPTH];
  logic signed [63:0] py[DEPTH];
  logic signed [63:0] pz[DEPTH];
  int                loaded;

  assign pending = accel_q.size();

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] b;
    x = v;
    res = 0;
    b = 64'h1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint pull_term(input longint d, input logic [127:0] den,
                                       inout logic flag);
    logic [63:0]  mag;
    logic [127:0] num;
    logic [127:0] q;
    longint       m;
    mag = (d < 0) ? -d : d;
    if (mag == 0 || gm == 0) return 0;
    num = ({96'b0, gm} * {64'b0, mag}) << 23;
    q = num / den;
    if (q > 128'(ACC_MAX)) begin
      flag = 1'b1;
      m = ACC_MAX;
    end else begin
      m = longint'(q[63:0]);
    end
    return (d < 0) ? -m : m;
  endfunction

  function automatic longint clamp_add(input longint s, input longint c, inout logic flag);
    longint t;
    t = s + c;
    if (t > ACC_MAX) begin
      flag = 1'b1;
      return ACC_MAX;
    end
    if (t < ACC_MIN) begin
      flag = 1'b1;
      return ACC_MIN;
    end
    return t;
  endfunction

  task automatic predict_set();
    logic [63:0]  e2;
    logic [63:0]  ax, ay, az, r, s;
    logic [127:0] den;
    longint       dx, dy, dz, sx, sy, sz;
    logic         flag;
    accel_t       a;
    e2 = ({32'b0, eps} * {32'b0, eps}) >> 16;
    for (int i = 0; i < loaded; i++) begin
      flag = 1'b0;
      sx = 0;
      sy = 0;
      sz = 0;
      for (int j = 0; j < loaded; j++) begin
        if (j == i) continue;
        dx = px[j] - px[i];
        dy = py[j] - py[i];
        dz = pz[j] - pz[i];
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        az = (dz < 0) ? -dz : dz;
        r = ((ax * ax) >> 16) + ((ay * ay) >> 16) + ((az * az) >> 16) + e2;
        if (r == 0) begin
          flag = 1'b1;
          continue;
        end
        s = isqrt(r << 14);
        den = {64'b0, r} * {64'b0, s};
        sx = clamp_add(sx, pull_term(dx, den, flag), flag);
        sy = clamp_add(sy, pull_term(dy, den, flag), flag);
        sz = clamp_add(sz, pull_term(dz, den, flag), flag);
      end
      a.ax = sx[47:0];
      a.ay = sy[47:0];
      a.az = sz[47:0];
      a.idx = i[5:0];
      a.ovf = flag;
      a.last = (i + 1 == loaded);
      if (flag) overflow_seen++;
      accel_q.push_back(a);
    end
    loaded = 0;
    sets_seen++;
  endtask

  initial begin
    fail_count = 0;
    results_seen = 0;
    sets_seen = 0;
    overflow_seen = 0;
    loaded = 0;
    gm = 32'd65536;
    eps = 32'd0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      gm <= 32'd65536;
      eps <= 32'd0;
      loaded = 0;
      accel_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == REG_GRAV_MASS) gm <= cfg_mon.data;
        else if (cfg_mon.index == REG_SOFTENING) eps <= cfg_mon.data;
      end
      if (out_mon.valid && out_mon.ready) begin
        results_seen++;
        if (accel_q.size() == 0) begin
          report("unexpected beat, index", out_mon.particle_index, -1);
        end else begin
          accel_t e;
          e = accel_q.pop_front();
          if (out_mon.acc_x !== e.ax) report("acc_x", out_mon.acc_x, e.ax);
          if (out_mon.acc_y !== e.ay) report("acc_y", out_mon.acc_y, e.ay);
          if (out_mon.acc_z !== e.az) report("acc_z", out_mon.acc_z, e.az);
          if (out_mon.particle_index !== e.idx)
            report("particle_index", out_mon.particle_index, e.idx);
          if (out_mon.overflow !== e.ovf) report("overflow", out_mon.overflow, e.ovf);
          if (out_mon.last_result !== e.last)
            report("last_result", out_mon.last_result, e.last);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        // drop positions once the store is full
        if (loaded < DEPTH) begin
          px[loaded] = in_mon.pos_x;
          py[loaded] = in_mon.pos_y;
          pz[loaded] = in_mon.pos_z;
          loaded++;
        end
        if (in_mon.last_particle) predict_set();
      end
    end
  end
endmodule

// File: verif/tb_nbody_pairwise_acceleration_unit.sv
module tb_nbody_pairwise_acceleration_unit;
  import nbpa_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count, pending, results_seen, sets_seen, overflow_seen;
  int   burst_left;
  int   items_sent;

  nbpa_in_if  in_ch();
  nbpa_out_if out_ch();
  nbpa_cfg_if cfg_ch();

  nbody_pairwise_acceleration_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  nbpa_accel_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen),
    .sets_seen(sets_seen), .overflow_seen(overflow_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(64'd20 * 64'd5_000_000);
    $display("timeout waiting for results");
    $display("TEST FAILED");
    $finish;
  end

  // receiver: switch between always ready, random stalls and long holds
  initial begin
    int mode;
    out_ch.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(20, 120)) begin
        @(negedge clk);
        case (mode)
          0: out_ch.ready = 1'b1;
          1: out_ch.ready = $urandom_range(0, 1);
          default: out_ch.ready = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic send_pos(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                          input logic last);
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 12) : 0) @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end
    in_ch.pos_x = x;
    in_ch.pos_y = y;
    in_ch.pos_z = z;
    in_ch.last_particle = last;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
    burst_left--;
    items_sent++;
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    cfg_ch.index = idx;
    cfg_ch.data = val;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord(input int mode, input logic [31:0] prev);
    case (mode)
      0: return $urandom_range(0, 1 << 19) - (1 << 18);
      1: return $urandom();
      2: return prev + $urandom_range(0, 3);
      default: return $urandom_range(0, 1 << 27) - (1 << 26);
    endcase
  endfunction

  task automatic random_set(input int n);
    logic [31:0] x, y, z;
    int mode;
    x = 0;
    y = 0;
    z = 0;
    for (int k = 0; k < n; k++) begin
      mode = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(0, 3);
      if (mode == 1) begin
        x = $urandom();
        y = $urandom();
        z = $urandom();
      end else begin
        x = rand_coord(mode, x);
        y = rand_coord(mode, y);
        z = rand_coord(mode, z);
      end
      send_pos(x, y, z, k == n - 1);
    end
  endtask

  task automatic random_regs();
    case ($urandom_range(0, 3))
      0: write_reg(REG_GRAV_MASS, 32'd65536);
      1: write_reg(REG_GRAV_MASS, 32'hFFFF_FFFF);
      2: write_reg(REG_GRAV_MASS, 32'd0);
      default: write_reg(REG_GRAV_MASS, $urandom());
    endcase
    case ($urandom_range(0, 3))
      0: write_reg(REG_SOFTENING, 32'd0);
      1: write_reg(REG_SOFTENING, $urandom_range(0, 1 << 17));
      2: write_reg(REG_SOFTENING, 32'hFFFF_FFFF);
      default: write_reg(REG_SOFTENING, $urandom());
    endcase
    // unknown index, must be ignored
    write_reg(8'($urandom_range(2, 255)), $urandom());
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    in_ch.last_particle = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    burst_left = 0;
    items_sent = 0;
    rst_n = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // reset registers: lone particle, then extreme opposite corners
    send_pos(32'h1234_5678, 32'hFFFF_0000, 32'h0, 1'b1);
    send_pos(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    // coincident pair, no softening
    send_pos(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0);
    send_pos(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b1);
    drain();

    // huge mass: clamped terms and saturated sums on a tight cluster
    write_reg(REG_GRAV_MASS, 32'hFFFF_FFFF);
    write_reg(8'hFF, 32'hDEAD_BEEF);
    send_pos(32'h0, 32'h0, 32'h0, 1'b0);
    send_pos(32'h1, 32'h0, 32'h0, 1'b0);
    send_pos(32'h2, 32'hFFFF_FFFF, 32'h0, 1'b0);
    send_pos(32'h3, 32'h0, 32'h1, 1'b1);
    drain();

    // zero mass with maximum softening
    write_reg(REG_GRAV_MASS, 32'd0);
    write_reg(REG_SOFTENING, 32'hFFFF_FFFF);
    send_pos(32'h0, 32'h0, 32'h0, 1'b0);
    send_pos(32'h0001_0000, 32'h0, 32'hFFFF_0000, 1'b1);
    drain();

    write_reg(REG_GRAV_MASS, 32'hFFFF_FFFF);
    send_pos(32'h0, 32'h0, 32'h0, 1'b0);
    send_pos(32'h0, 32'h0, 32'h0, 1'b0);
    send_pos(32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 1'b1);
    drain();

    // full store: two extra positions are dropped, the last one closes the set
    write_reg(REG_GRAV_MASS, 32'd65536);
    write_reg(REG_SOFTENING, 32'h0000_4000);
    for (int k = 0; k < 66; k++)
      send_pos($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20), $urandom(), k == 65);
    drain();

    while (items_sent < 200) begin
      random_regs();
      repeat ($urandom_range(2, 5)) random_set($urandom_range(1, 8));
      drain();
    end

    drain();
    $display("covered %0d position beats in %0d sets, %0d accelerations checked",
             items_sent, sets_seen, results_seen);
    $display("%0d accelerations carried the overflow flag", overflow_seen);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
